>>> rtl/double_ended_queue_top_defines.svh
// assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// checked only while reset is released
`define DEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/deq_pkg.sv
// shared types and constants of the double-ended queue
package deq_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FUNC_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

	localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

	typedef struct packed {
		logic ins_front;
		logic ins_back;
		logic rm_front;
		logic rm_back;
		logic rd;
		logic ld;
		logic rej;
	} deq_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
	} deq_stat_t;

endpackage

>>> rtl/deq_ctrl.sv
// sequencer: accepts one word, walks it through update, read and result load
module deq_ctrl
	import deq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	output logic              out_valid,
	input  logic              out_ready,
	input  deq_stat_t         stat,
	output deq_cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   rej_q;
	logic   accept;
	logic   can_load;
	logic   is_push;
	logic   is_pop;
	logic   reject;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign can_load = (state_q == ST_LOAD) && (!out_valid_q || out_ready);

	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		case (func)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: is_push = 1'b1;
			FUNC_POP_FRONT, FUNC_POP_BACK:   is_pop  = 1'b1;
			default: ;
		endcase
	end

	assign reject = (is_push && stat.cnt_full) || (is_pop && stat.cnt_zero);

	always_comb begin
		cmd           = '0;
		cmd.ins_front = accept && !reject && (func == FUNC_PUSH_FRONT);
		cmd.ins_back  = accept && !reject && (func == FUNC_PUSH_BACK);
		cmd.rm_front  = accept && !reject && (func == FUNC_POP_FRONT);
		cmd.rm_back   = accept && !reject && (func == FUNC_POP_BACK);
		cmd.rd        = (state_q == ST_READ);
		cmd.ld        = can_load;
		cmd.rej       = rej_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !can_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rej_q   <= reject;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// result register frees up as the old word leaves
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/deq_dp.sv
// datapath: ring store, head and count registers, read and result registers
module deq_dp
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4,
	parameter int unsigned CW    = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  deq_cmd_t                 cmd,
	input  logic signed [DATA_W-1:0] value,
	output deq_stat_t                stat,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic                     is_empty,
	output logic                     is_full,
	output logic                     rejected
);

	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [AW-1:0]            head_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            head_prev;
	logic [AW-1:0]            head_next;
	logic [AW:0]              tail_sum;
	logic [AW:0]              back_sum;
	logic [AW-1:0]            tail_addr;
	logic [AW-1:0]            back_addr;
	logic [AW-1:0]            wr_addr;
	logic                     wr_en;
	logic signed [DATA_W-1:0] front_rd_q;
	logic signed [DATA_W-1:0] back_rd_q;
	logic signed [DATA_W-1:0] front_value_q;
	logic signed [DATA_W-1:0] back_value_q;
	logic                     is_empty_q;
	logic                     is_full_q;
	logic                     rejected_q;

	assign stat.cnt_zero = (count_q == '0);
	assign stat.cnt_full = (count_q == FULL_C);

	assign head_prev = (head_q == '0) ? LAST : head_q - 1'b1;
	assign head_next = (head_q == LAST) ? '0 : head_q + 1'b1;

	// sums stay below twice the depth, so one subtract wraps them
	assign tail_sum  = {1'b0, head_q} + (AW+1)'(count_q);
	assign back_sum  = tail_sum - 1'b1;
	assign tail_addr = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
	assign back_addr = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);

	assign wr_en   = cmd.ins_front || cmd.ins_back;
	assign wr_addr = cmd.ins_front ? head_prev : tail_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.ins_front) begin
				head_q <= head_prev;
			end else if (cmd.rm_front) begin
				head_q <= head_next;
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.rm_front || cmd.rm_back) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			front_rd_q <= mem[head_q];
			back_rd_q  <= mem[back_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			front_value_q <= stat.cnt_zero ? EMPTY_MARK : front_rd_q;
			back_value_q  <= stat.cnt_zero ? EMPTY_MARK : back_rd_q;
			is_empty_q    <= stat.cnt_zero;
			is_full_q     <= stat.cnt_full;
			rejected_q    <= cmd.rej;
		end
	end

	assign front_value = front_value_q;
	assign back_value  = back_value_q;
	assign is_empty    = is_empty_q;
	assign is_full     = is_full_q;
	assign rejected    = rejected_q;

endmodule

>>> rtl/double_ended_queue_top.sv
// top level of the bounded double-ended queue
//
//  channel  handshake            payload
//  in       in_valid / in_ready  func, value
//  out      out_valid/out_ready  front_value, back_value, is_empty, is_full, rejected
//
// each word passes three steps: accept and store update, store read, result load
// the store has one write and two read ports with registered read data
// a new word is taken while the previous result still waits in the output register
// a stalled output holds the load step until that result is taken
// reset clears head and count; the store contents are not cleared
module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic                     is_empty,
	output logic                     is_full,
	output logic                     rejected
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.stat        (stat),
		.front_value (front_value),
		.back_value  (back_value),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.rejected    (rejected)
	);

endmodule

>>> rtl/deq_chk.sv
// port-level checks on the deque top, attached by bind
`include "double_ended_queue_top_defines.svh"

module deq_chk
	import deq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] front_value,
	input logic signed [DATA_W-1:0] back_value,
	input logic                     is_empty,
	input logic                     is_full
);

	// one word in flight at a time
	`DEQ_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "word taken while busy")
	`DEQ_ASSERT(a_empty_marks, (out_valid && is_empty) |-> (front_value == EMPTY_MARK && back_value == EMPTY_MARK), "empty result without marks")
	`DEQ_ASSERT(a_flags_exclusive, out_valid |-> !(is_empty && is_full), "empty and full together")
	`DEQ_ASSERT_ALWAYS(a_hold_stall, (arst_n && out_valid && !out_ready) |=> (!arst_n || (out_valid && $stable(front_value) && $stable(back_value))), "stalled result changed")

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.front_value (front_value),
	.back_value  (back_value),
	.is_empty    (is_empty),
	.is_full     (is_full)
);

>>> verif/testbench.sv
// testbench for the double-ended queue, checked against a shadow deque
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import deq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_OPS = 900;
	localparam int PHASE_LEN = 230;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {PACE_FREE, PACE_SLOW_SRC, PACE_SLOW_SINK, PACE_BOTH} pace_t;
	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	typedef struct {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value;
		pace_t                    pace;
	} deq_word_t;

	typedef struct {
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic                     is_empty;
		logic                     is_full;
		logic                     rejected;
	} deq_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = FUNC_QUERY;
	logic signed [DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic is_empty;
	logic is_full;
	logic rejected;

	deq_word_t pending_words[$];
	deq_view_t awaited_views[$];
	logic in_fire = 1'b0;
	int words_taken = 0;
	pace_t pace_now = PACE_FREE;
	int hold_left = 0;
	logic hold_used = 1'b0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	// shadow copy of the ring store
	logic signed [DATA_W-1:0] shadow_slots [DEPTH];
	logic [3:0] shadow_head = '0;
	logic [4:0] shadow_count = '0;

	double_ended_queue_top #(.DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.front_value(front_value),
		.back_value(back_value),
		.is_empty(is_empty),
		.is_full(is_full),
		.rejected(rejected)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic deque_step(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
			output deq_view_t r);
		logic [3:0] tail;
		r.rejected = 1'b0;
		case (f)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
				if (shadow_count == 5'(DEPTH)) begin
					r.rejected = 1'b1;
				end else if (f == FUNC_PUSH_FRONT) begin
					shadow_head = shadow_head - 4'd1;
					shadow_slots[shadow_head] = v;
					shadow_count = shadow_count + 5'd1;
				end else begin
					shadow_slots[shadow_head + shadow_count[3:0]] = v;
					shadow_count = shadow_count + 5'd1;
				end
			end
			FUNC_POP_FRONT, FUNC_POP_BACK: begin
				if (shadow_count == 5'd0) begin
					r.rejected = 1'b1;
				end else begin
					if (f == FUNC_POP_FRONT)
						shadow_head = shadow_head + 4'd1;
					shadow_count = shadow_count - 5'd1;
				end
			end
			default: ; // query and the unused codes change nothing
		endcase
		tail = shadow_head + shadow_count[3:0] - 4'd1;
		r.is_empty = (shadow_count == 5'd0);
		r.is_full = (shadow_count == 5'(DEPTH));
		r.front_value = r.is_empty ? EMPTY_MARK : shadow_slots[shadow_head];
		r.back_value = r.is_empty ? EMPTY_MARK : shadow_slots[tail];
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return EMPTY_MARK;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] pick_func(input mix_t mix);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(99);
		push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 20 : 40;
		pop_pct = (mix == MIX_EVEN) ? 40 : (mix == MIX_FILL) ? 20 : 70;
		if (r < push_pct)
			return $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
		else if (r < push_pct + pop_pct)
			return $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
		else
			return FUNC_QUERY + FUNC_W'($urandom_range(3));
	endfunction

	function automatic void queue_word(input logic [FUNC_W-1:0] f,
			input logic signed [DATA_W-1:0] v);
		deq_word_t w;
		w.func = f;
		w.value = v;
		w.pace = pace_t'((pending_words.size() / PHASE_LEN) % 4);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// record acceptance on the rising edge, act on it at the falling edge
	always @(posedge clk)
		in_fire <= arst_n && in_valid && in_ready;

	always @(negedge clk) begin : drive_proc
		deq_word_t w;
		deq_view_t v;
		logic go;
		if (arst_n) begin
			if (in_fire) begin
				w = pending_words[0];
				pending_words.delete(0);
				deque_step(w.func, w.value, v);
				awaited_views.insert(awaited_views.size(), v);
				words_taken <= words_taken + 1;
				pace_now <= w.pace;
			end
			if (!in_valid || in_fire) begin
				go = 1'b0;
				if (pending_words.size() != 0) begin
					case (pending_words[0].pace)
						PACE_SLOW_SRC: go = ($urandom_range(99) >= 76);
						PACE_BOTH:     go = ($urandom_range(99) >= 9);
						default:       go = 1'b1;
					endcase
				end
				in_valid <= go;
				if (go) begin
					func <= pending_words[0].func;
					value <= pending_words[0].value;
				end
			end
		end
	end

	// one long output stall while the sender keeps offering words
	always @(negedge clk) begin : hold_proc
		if (!hold_used && words_taken >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin : sink_proc
		logic take;
		case (pace_now)
			PACE_SLOW_SINK: take = ($urandom_range(99) >= 76);
			PACE_BOTH:      take = ($urandom_range(99) >= 9);
			default:        take = 1'b1;
		endcase
		out_ready <= arst_n && hold_left == 0 && take;
	end

	always @(posedge clk) begin : check_proc
		deq_view_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_views.size() == 0) begin
				$error("result word with no operation outstanding");
				fail_cnt++;
			end else begin
				want = awaited_views[0];
				awaited_views.delete(0);
				if (front_value !== want.front_value) begin
					$error("front_value expected %0d got %0d", want.front_value, front_value);
					fail_cnt++;
				end
				if (back_value !== want.back_value) begin
					$error("back_value expected %0d got %0d", want.back_value, back_value);
					fail_cnt++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty expected %0b got %0b", want.is_empty, is_empty);
					fail_cnt++;
				end
				if (is_full !== want.is_full) begin
					$error("is_full expected %0b got %0b", want.is_full, is_full);
					fail_cnt++;
				end
				if (rejected !== want.rejected) begin
					$error("rejected expected %0b got %0b", want.rejected, rejected);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("double_ended_queue_top: mismatch");
			$finish;
		end
	end

	initial begin : stim_proc
		mix_t mix;
		int left_in_burst;
		// empty deque: query, pops, unused codes
		queue_word(FUNC_QUERY, 32'sh1234_5678);
		queue_word(FUNC_POP_FRONT, '0);
		queue_word(FUNC_POP_BACK, '1);
		queue_word(3'd5, 32'sh7fff_ffff);
		queue_word(3'd6, 32'sh8000_0000);
		queue_word(3'd7, '1);
		// extremes at both ends
		queue_word(FUNC_PUSH_FRONT, 32'sh8000_0000);
		queue_word(FUNC_PUSH_BACK, 32'sh7fff_ffff);
		queue_word(FUNC_QUERY, '0);
		queue_word(FUNC_PUSH_FRONT, '0);
		queue_word(FUNC_PUSH_BACK, EMPTY_MARK);
		queue_word(3'd7, 32'sh5555_aaaa);
		queue_word(FUNC_POP_FRONT, '0);
		queue_word(FUNC_POP_BACK, '0);
		queue_word(FUNC_POP_FRONT, '0);
		queue_word(FUNC_POP_BACK, '0);
		queue_word(FUNC_POP_FRONT, '0);
		// random bursts that drive the deque to full and back to empty
		left_in_burst = 0;
		mix = MIX_FILL;
		repeat (RANDOM_OPS) begin
			if (left_in_burst == 0) begin
				mix = mix_t'($urandom_range(2));
				left_in_burst = $urandom_range(40, 10);
			end
			left_in_burst--;
			queue_word(pick_func(mix), pick_value());
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || awaited_views.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("double_ended_queue_top: match");
		else
			$display("double_ended_queue_top: mismatch");
		$finish;
	end

endmodule
